// ===== src/sup_pkg.sv =====
// ----------------------------------------------------------------------------
// sup_pkg
// types and constants shared by the udp request header parser modules
// ----------------------------------------------------------------------------
package sup_pkg;

    // parse phase of the current datagram
    typedef enum logic [2:0] {
        PH_RSV  = 3'd0,
        PH_FRAG = 3'd1,
        PH_ATYP = 3'd2,
        PH_DLEN = 3'd3,
        PH_ADDR = 3'd4,
        PH_PHI  = 3'd5,
        PH_PLO  = 3'd6,
        PH_PAY  = 3'd7
    } phase_t;

    // result kind codes
    typedef enum logic [1:0] {
        KIND_ADDR = 2'd0,
        KIND_HDR  = 2'd1,
        KIND_PAY  = 2'd2,
        KIND_DROP = 2'd3
    } kind_t;

    // address type byte values on the wire
    localparam logic [7:0] ATYP_V4  = 8'd1;
    localparam logic [7:0] ATYP_DOM = 8'd3;
    localparam logic [7:0] ATYP_V6  = 8'd4;

    // address kind codes on the result
    localparam logic [1:0] AKIND_V4  = 2'd0;
    localparam logic [1:0] AKIND_V6  = 2'd1;
    localparam logic [1:0] AKIND_DOM = 2'd2;

    // fixed address lengths
    localparam logic [7:0] LEN_V4 = 8'd4;
    localparam logic [7:0] LEN_V6 = 8'd16;

    // number of reserved bytes at the head of the datagram
    localparam logic [7:0] RSV_BYTES = 8'd2;

    // fragment byte with a zero fragment number but the final flag set
    localparam logic [7:0] FRAG_BAD = 8'h80;

    // one result item
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  byte_out;
        logic [7:0]  address_index;
        logic [1:0]  address_kind;
        logic [7:0]  address_length;
        logic [15:0] dest_port;
        logic [6:0]  fragment_number;
        logic        fragment_final;
        logic        standalone;
        logic        packet_done;
    } res_t;

endpackage

// ===== src/sup_in_if.sv =====
// ----------------------------------------------------------------------------
// sup_in_if
// input channel: one datagram byte per item with an end of packet mark
// ----------------------------------------------------------------------------
interface sup_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       end_of_packet;

    modport source (output valid, output byte_in, output end_of_packet, input ready);
    modport sink   (input valid, input byte_in, input end_of_packet, output ready);
endinterface

// ===== src/sup_out_if.sv =====
// ----------------------------------------------------------------------------
// sup_out_if
// result channel: address bytes, header result, payload bytes and drops
// ----------------------------------------------------------------------------
interface sup_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  byte_out;
    logic [7:0]  address_index;
    logic [1:0]  address_kind;
    logic [7:0]  address_length;
    logic [15:0] dest_port;
    logic [6:0]  fragment_number;
    logic        fragment_final;
    logic        standalone;
    logic        packet_done;

    modport source (
        output valid, output kind, output byte_out, output address_index,
        output address_kind, output address_length, output dest_port,
        output fragment_number, output fragment_final, output standalone,
        output packet_done, input ready
    );
    modport sink (
        input valid, input kind, input byte_out, input address_index,
        input address_kind, input address_length, input dest_port,
        input fragment_number, input fragment_final, input standalone,
        input packet_done, output ready
    );
endinterface

// ===== src/sup_step.sv =====
// ----------------------------------------------------------------------------
// sup_step
// parse state registers and the per-byte next state and result logic
// ----------------------------------------------------------------------------
module sup_step (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        byte_in,
    input  logic              end_of_packet,
    output logic              res_valid,
    output sup_pkg::res_t     res
);

    sup_pkg::phase_t phase_reg, phase_next;
    logic [7:0] byte_position_reg, byte_position_next;
    logic [7:0] addr_len_held_reg, addr_len_held_next;
    logic [1:0] addr_kind_held_reg, addr_kind_held_next;
    logic [7:0] frag_byte_held_reg, frag_byte_held_next;
    logic [7:0] port_high_held_reg, port_high_held_next;
    logic       discarding_reg, discarding_next;

    logic [7:0] pos_inc;
    logic       atyp_known;
    logic       drop_now;

    assign pos_inc    = byte_position_reg + 8'd1;
    assign atyp_known = (byte_in == sup_pkg::ATYP_V4) || (byte_in == sup_pkg::ATYP_V6) ||
                        (byte_in == sup_pkg::ATYP_DOM);

    // malformed or truncated header at this byte
    always_comb
    begin
        case (phase_reg)
            sup_pkg::PH_RSV:  drop_now = end_of_packet;
            sup_pkg::PH_FRAG: drop_now = end_of_packet || (byte_in == sup_pkg::FRAG_BAD);
            sup_pkg::PH_ATYP: drop_now = end_of_packet || !atyp_known;
            sup_pkg::PH_DLEN: drop_now = end_of_packet || (byte_in == 8'd0);
            sup_pkg::PH_ADDR: drop_now = end_of_packet;
            sup_pkg::PH_PHI:  drop_now = end_of_packet;
            default:          drop_now = 1'b0;
        endcase
    end

    // next state
    always_comb
    begin
        phase_next          = phase_reg;
        byte_position_next  = byte_position_reg;
        addr_len_held_next  = addr_len_held_reg;
        addr_kind_held_next = addr_kind_held_reg;
        frag_byte_held_next = frag_byte_held_reg;
        port_high_held_next = port_high_held_reg;
        discarding_next     = discarding_reg;
        if (discarding_reg)
        begin
            if (end_of_packet)
            begin
                discarding_next    = 1'b0;
                phase_next         = sup_pkg::PH_RSV;
                byte_position_next = 8'd0;
            end
        end
        else
        begin
            case (phase_reg)
                sup_pkg::PH_RSV:
                begin
                    byte_position_next = pos_inc;
                    if (pos_inc >= sup_pkg::RSV_BYTES)
                    begin
                        byte_position_next = 8'd0;
                        phase_next         = sup_pkg::PH_FRAG;
                    end
                end
                sup_pkg::PH_FRAG:
                begin
                    frag_byte_held_next = byte_in;
                    phase_next          = sup_pkg::PH_ATYP;
                end
                sup_pkg::PH_ATYP:
                begin
                    byte_position_next = 8'd0;
                    if (byte_in == sup_pkg::ATYP_V4)
                    begin
                        addr_kind_held_next = sup_pkg::AKIND_V4;
                        addr_len_held_next  = sup_pkg::LEN_V4;
                        phase_next          = sup_pkg::PH_ADDR;
                    end
                    else if (byte_in == sup_pkg::ATYP_V6)
                    begin
                        addr_kind_held_next = sup_pkg::AKIND_V6;
                        addr_len_held_next  = sup_pkg::LEN_V6;
                        phase_next          = sup_pkg::PH_ADDR;
                    end
                    else if (byte_in == sup_pkg::ATYP_DOM)
                    begin
                        addr_kind_held_next = sup_pkg::AKIND_DOM;
                        phase_next          = sup_pkg::PH_DLEN;
                    end
                end
                sup_pkg::PH_DLEN:
                begin
                    // length is kept only when the byte is good
                    if (!drop_now)
                    begin
                        addr_len_held_next = byte_in;
                    end
                    phase_next = sup_pkg::PH_ADDR;
                end
                sup_pkg::PH_ADDR:
                begin
                    byte_position_next = pos_inc;
                    if (pos_inc >= addr_len_held_reg)
                    begin
                        byte_position_next = 8'd0;
                        phase_next         = sup_pkg::PH_PHI;
                    end
                end
                sup_pkg::PH_PHI:
                begin
                    if (!drop_now)
                    begin
                        port_high_held_next = byte_in;
                    end
                    phase_next = sup_pkg::PH_PLO;
                end
                sup_pkg::PH_PLO:
                begin
                    if (end_of_packet)
                    begin
                        phase_next         = sup_pkg::PH_RSV;
                        byte_position_next = 8'd0;
                    end
                    else
                    begin
                        phase_next = sup_pkg::PH_PAY;
                    end
                end
                default:
                begin
                    if (end_of_packet)
                    begin
                        phase_next         = sup_pkg::PH_RSV;
                        byte_position_next = 8'd0;
                    end
                end
            endcase
            // a drop restarts parsing, and skips the rest unless this was the last byte
            if (drop_now)
            begin
                phase_next         = sup_pkg::PH_RSV;
                byte_position_next = 8'd0;
                discarding_next    = !end_of_packet;
            end
        end
    end

    // result
    always_comb
    begin
        res       = '0;
        res.kind  = sup_pkg::KIND_ADDR;
        res_valid = 1'b0;
        if (!discarding_reg)
        begin
            if (drop_now)
            begin
                res_valid       = 1'b1;
                res.kind        = sup_pkg::KIND_DROP;
                res.packet_done = 1'b1;
            end
            else
            begin
                case (phase_reg)
                    sup_pkg::PH_ADDR:
                    begin
                        res_valid          = 1'b1;
                        res.kind           = sup_pkg::KIND_ADDR;
                        res.byte_out       = byte_in;
                        res.address_index  = byte_position_reg;
                        res.address_kind   = addr_kind_held_reg;
                        res.address_length = addr_len_held_reg;
                    end
                    sup_pkg::PH_PLO:
                    begin
                        res_valid           = 1'b1;
                        res.kind            = sup_pkg::KIND_HDR;
                        res.address_kind    = addr_kind_held_reg;
                        res.address_length  = addr_len_held_reg;
                        res.dest_port       = {port_high_held_reg, byte_in};
                        res.fragment_number = frag_byte_held_reg[6:0];
                        res.fragment_final  = frag_byte_held_reg[7];
                        res.standalone      = (frag_byte_held_reg == 8'd0);
                        res.packet_done     = end_of_packet;
                    end
                    sup_pkg::PH_PAY:
                    begin
                        res_valid       = 1'b1;
                        res.kind        = sup_pkg::KIND_PAY;
                        res.byte_out    = byte_in;
                        res.packet_done = end_of_packet;
                    end
                    default:
                    begin
                        res_valid = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= sup_pkg::PH_RSV;
            byte_position_reg  <= 8'd0;
            addr_len_held_reg  <= 8'd0;
            addr_kind_held_reg <= 2'd0;
            frag_byte_held_reg <= 8'd0;
            port_high_held_reg <= 8'd0;
            discarding_reg     <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg          <= phase_next;
            byte_position_reg  <= byte_position_next;
            addr_len_held_reg  <= addr_len_held_next;
            addr_kind_held_reg <= addr_kind_held_next;
            frag_byte_held_reg <= frag_byte_held_next;
            port_high_held_reg <= port_high_held_next;
            discarding_reg     <= discarding_next;
        end
    end

endmodule

// ===== src/sup_out_reg.sv =====
// ----------------------------------------------------------------------------
// sup_out_reg
// result register driving the output channel
// ----------------------------------------------------------------------------
module sup_out_reg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  logic          res_valid,
    input  sup_pkg::res_t res,
    output logic          can_load,
    sup_out_if.source     dout
);

    logic          valid_reg, valid_next;
    sup_pkg::res_t res_reg;

    // register is free when empty or being emptied this cycle
    assign can_load = !valid_reg || dout.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (valid_reg && dout.ready)
        begin
            valid_next = 1'b0;
        end
        if (load && res_valid)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign dout.valid           = valid_reg;
    assign dout.kind            = res_reg.kind;
    assign dout.byte_out        = res_reg.byte_out;
    assign dout.address_index   = res_reg.address_index;
    assign dout.address_kind    = res_reg.address_kind;
    assign dout.address_length  = res_reg.address_length;
    assign dout.dest_port       = res_reg.dest_port;
    assign dout.fragment_number = res_reg.fragment_number;
    assign dout.fragment_final  = res_reg.fragment_final;
    assign dout.standalone      = res_reg.standalone;
    assign dout.packet_done     = res_reg.packet_done;

endmodule

// ===== src/socks5_udp_header_parser.sv =====
// ----------------------------------------------------------------------------
// socks5_udp_header_parser
// streaming parser for the request header of a proxied udp datagram
//
// takes one datagram byte per item on din, with end_of_packet on the last
// byte. the two reserved bytes are skipped, the fragment byte is kept, and
// the address type selects ipv4 (4 bytes), ipv6 (16 bytes) or a domain name
// with a length byte in front. each address byte comes out as its own item
// with its index, then one header item carries the big-endian port, the
// address kind and length and the fragment fields; every later byte is a
// payload item. an unknown address type, a zero domain length, a fragment
// byte of 0x80 or a datagram that ends inside the header gives one drop item
// and the rest of that datagram is swallowed without results; address items
// already sent for it are then void. packet_done marks the last item a
// datagram causes. the parse state advances on each accepted byte and the
// result lands in one output register, so one byte per cycle is taken while
// dout keeps up, and din stalls only while the output register holds an item
// that dout has not taken.
// ----------------------------------------------------------------------------
module socks5_udp_header_parser (
    input  logic      clk,
    input  logic      rst_n,
    sup_in_if.sink    din,
    sup_out_if.source dout
);

    logic          accept;
    logic          can_load;
    logic          res_valid;
    sup_pkg::res_t res;

    // input byte taken when the result register has room
    assign din.ready = can_load;
    assign accept    = din.valid && can_load;

    // phase tracking and per-byte result
    sup_step u_step (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .byte_in       (din.byte_in),
        .end_of_packet (din.end_of_packet),
        .res_valid     (res_valid),
        .res           (res)
    );

    // result register toward dout
    sup_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .res_valid (res_valid),
        .res       (res),
        .can_load  (can_load),
        .dout      (dout)
    );

endmodule

// ===== tb/socks5_udp_header_parser_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// socks5_udp_header_parser_test
// self-checking bench for the udp request header parser: a directed table of
// datagrams for the drop cases and field extremes, then random datagrams
// (mostly well-formed, some truncated or corrupted, some plain noise) under
// random stalls on both channels, each result checked against a predictor
// ----------------------------------------------------------------------------
module socks5_udp_header_parser_test;

    // how a directed row gets its expectation
    typedef enum {
        ROW_PREDICT,  // from the predictor
        ROW_NONE,     // no result for this byte
        ROW_FIXED     // typed-in result
    } row_mode_t;

    typedef struct {
        logic [7:0]     data;
        logic           eop;
        row_mode_t      mode;
        sup_pkg::res_t  want;
    } stim_row_t;

    localparam int CLK_PERIOD   = 12;
    localparam int TOTAL_BYTES  = 1450;
    localparam int DUE_DEPTH    = 64;
    localparam int ROW_DEPTH    = 64;
    localparam int DG_DEPTH     = 512;

    logic clk;
    logic rst_n;

    sup_in_if  din_if ();
    sup_out_if dout_if ();

    socks5_udp_header_parser dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_if),
        .dout  (dout_if)
    );

    // predictor state, one copy of the parser's datagram context
    sup_pkg::phase_t p_phase;
    logic [7:0] p_pos;
    logic [7:0] p_len;
    logic [1:0] p_akind;
    logic [7:0] p_frag;
    logic [7:0] p_port_hi;
    logic       p_discard;

    // results still owed by the parser, oldest first, as a ring
    sup_pkg::res_t due_buf[DUE_DEPTH];
    int due_wr;
    int due_rd;

    stim_row_t stim_rows[ROW_DEPTH];
    int n_rows;

    logic [7:0] datagram[DG_DEPTH];
    int dg_len;

    int errors;
    int bytes_sent;
    int datagrams;
    int results_seen;
    int kind_seen[4];
    int src_pct;
    int sink_pct;

    // ------------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // ------------------------------------------------------------------------
    // mismatch reporting: one line per failure, every failure counts
    // ------------------------------------------------------------------------
    task automatic report(input string msg);
        errors++;
        $display("[%0t] error: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------------
    // owed results ring
    // ------------------------------------------------------------------------
    function automatic int due_count();
        return due_wr - due_rd;
    endfunction

    task automatic owe_result(input sup_pkg::res_t r);
        if (due_count() >= DUE_DEPTH)
        begin
            report("too many results outstanding");
            return;
        end
        due_buf[due_wr % DUE_DEPTH] = r;
        due_wr++;
    endtask

    function automatic sup_pkg::res_t take_result();
        sup_pkg::res_t r;
        r = due_buf[due_rd % DUE_DEPTH];
        due_rd++;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic void restart_parse();
        p_phase = sup_pkg::PH_RSV;
        p_pos   = '0;
    endfunction

    // malformed datagram: one drop item, swallow the rest unless this was the end
    function automatic bit abort_datagram(input logic eop, output sup_pkg::res_t r);
        r             = '0;
        r.kind        = sup_pkg::KIND_DROP;
        r.packet_done = 1'b1;
        restart_parse();
        p_discard     = !eop;
        return 1'b1;
    endfunction

    function automatic void reset_parse();
        restart_parse();
        p_len     = '0;
        p_akind   = '0;
        p_frag    = '0;
        p_port_hi = '0;
        p_discard = 1'b0;
    endfunction

    // advance the datagram context by one byte; returns 1 when a result is due
    function automatic bit parse_byte(input logic [7:0] b, input logic eop,
                                      output sup_pkg::res_t r);
        r = '0;
        if (p_discard)
        begin
            // the end of a dropped datagram is swallowed too, then parsing restarts
            if (eop)
            begin
                p_discard = 1'b0;
                restart_parse();
            end
            return 1'b0;
        end
        case (p_phase)
            sup_pkg::PH_RSV:
            begin
                if (eop)
                    return abort_datagram(eop, r);
                p_pos = p_pos + 8'd1;
                if (p_pos >= sup_pkg::RSV_BYTES)
                begin
                    p_pos   = '0;
                    p_phase = sup_pkg::PH_FRAG;
                end
                return 1'b0;
            end
            sup_pkg::PH_FRAG:
            begin
                p_frag = b;
                if (eop || b == sup_pkg::FRAG_BAD)
                    return abort_datagram(eop, r);
                p_phase = sup_pkg::PH_ATYP;
                return 1'b0;
            end
            sup_pkg::PH_ATYP:
            begin
                p_pos = '0;
                if (b == sup_pkg::ATYP_V4)
                begin
                    p_akind = sup_pkg::AKIND_V4;
                    p_len   = sup_pkg::LEN_V4;
                    p_phase = sup_pkg::PH_ADDR;
                end
                else if (b == sup_pkg::ATYP_V6)
                begin
                    p_akind = sup_pkg::AKIND_V6;
                    p_len   = sup_pkg::LEN_V6;
                    p_phase = sup_pkg::PH_ADDR;
                end
                else if (b == sup_pkg::ATYP_DOM)
                begin
                    p_akind = sup_pkg::AKIND_DOM;
                    p_phase = sup_pkg::PH_DLEN;
                end
                else
                    return abort_datagram(eop, r);
                if (eop)
                    return abort_datagram(eop, r);
                return 1'b0;
            end
            sup_pkg::PH_DLEN:
            begin
                if (b == 8'd0 || eop)
                    return abort_datagram(eop, r);
                p_len   = b;
                p_phase = sup_pkg::PH_ADDR;
                return 1'b0;
            end
            sup_pkg::PH_ADDR:
            begin
                if (eop)
                    return abort_datagram(eop, r);
                r.kind           = sup_pkg::KIND_ADDR;
                r.byte_out       = b;
                r.address_index  = p_pos;
                r.address_kind   = p_akind;
                r.address_length = p_len;
                p_pos = p_pos + 8'd1;
                if (p_pos >= p_len)
                begin
                    p_pos   = '0;
                    p_phase = sup_pkg::PH_PHI;
                end
                return 1'b1;
            end
            sup_pkg::PH_PHI:
            begin
                if (eop)
                    return abort_datagram(eop, r);
                p_port_hi = b;
                p_phase   = sup_pkg::PH_PLO;
                return 1'b0;
            end
            sup_pkg::PH_PLO:
            begin
                r.kind            = sup_pkg::KIND_HDR;
                r.address_kind    = p_akind;
                r.address_length  = p_len;
                r.dest_port       = {p_port_hi, b};
                r.fragment_number = p_frag[6:0];
                r.fragment_final  = p_frag[7];
                r.standalone      = (p_frag == 8'd0);
                r.packet_done     = eop;
                if (eop)
                    restart_parse();
                else
                    p_phase = sup_pkg::PH_PAY;
                return 1'b1;
            end
            default:
            begin
                r.kind        = sup_pkg::KIND_PAY;
                r.byte_out    = b;
                r.packet_done = eop;
                if (eop)
                    restart_parse();
                return 1'b1;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // idle lengths: mostly none or short, now and then a long one
    // ------------------------------------------------------------------------
    function automatic int pick_gap(input int pct);
        if ($urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 30);
        return $urandom_range(1, 3);
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 3))
            0:       return 0;
            3:       return 50;
            default: return 15;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------

    // offer one byte and hold it until taken, then step the predictor
    task automatic offer_byte(input logic [7:0] b, input logic eop,
                              output bit has, output sup_pkg::res_t r);
        din_if.valid         <= 1'b1;
        din_if.byte_in       <= b;
        din_if.end_of_packet <= eop;
        do
            @(posedge clk);
        while (!(din_if.valid && din_if.ready));
        bytes_sent++;
        has = parse_byte(b, eop, r);
    endtask

    // valid drops only when the sender pauses before the next offer
    task automatic sender_pause();
        int gap;
        gap = pick_gap(src_pct);
        if (gap > 0)
        begin
            din_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic void add_row(input logic [7:0] data, input logic eop,
                                    input row_mode_t mode, input sup_pkg::res_t want);
        stim_rows[n_rows].data = data;
        stim_rows[n_rows].eop  = eop;
        stim_rows[n_rows].mode = mode;
        stim_rows[n_rows].want = want;
        n_rows++;
    endfunction

    function automatic void dg_add(input logic [7:0] b);
        if (dg_len < DG_DEPTH)
        begin
            datagram[dg_len] = b;
            dg_len++;
        end
    endfunction

    // one well-formed request; returns the header length
    function automatic int build_request();
        int n;
        logic [7:0] frag;
        dg_len = 0;
        dg_add(8'($urandom));
        dg_add(8'($urandom));
        case ($urandom_range(0, 3))
            0:       frag = 8'h00;
            1:       frag = {1'b1, 7'($urandom_range(1, 127))};
            2:       frag = {1'b0, 7'($urandom)};
            default: frag = 8'($urandom);
        endcase
        if (frag == sup_pkg::FRAG_BAD)
            frag = 8'h00;
        dg_add(frag);
        case ($urandom_range(0, 2))
            0:
            begin
                dg_add(sup_pkg::ATYP_V4);
                n = sup_pkg::LEN_V4;
            end
            1:
            begin
                dg_add(sup_pkg::ATYP_V6);
                n = sup_pkg::LEN_V6;
            end
            default:
            begin
                // long names are rare so the run stays short
                n = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 255)
                                                 : $urandom_range(1, 12);
                dg_add(sup_pkg::ATYP_DOM);
                dg_add(8'(n));
            end
        endcase
        repeat (n) dg_add(8'($urandom));
        case ($urandom_range(0, 5))
            0:
            begin
                dg_add(8'h00);
                dg_add(8'h00);
            end
            1:
            begin
                dg_add(8'hff);
                dg_add(8'hff);
            end
            default:
            begin
                dg_add(8'($urandom));
                dg_add(8'($urandom));
            end
        endcase
        return dg_len;
    endfunction

    // fill the datagram buffer: well-formed, truncated, corrupted or noise
    function automatic void make_datagram();
        int hdr_len;
        int sel;
        int cut;
        logic [7:0] bad;
        hdr_len = 0;
        sel = $urandom_range(0, 99);
        if (sel < 90)
        begin
            hdr_len = build_request();
            // payload, empty now and then so the header is the final byte
            if ($urandom_range(0, 3) != 0)
                repeat ($urandom_range(1, 10)) dg_add(8'($urandom));
        end
        if (sel >= 70 && sel < 80)
        begin
            // ends somewhere inside the header or on its last byte
            cut = $urandom_range(1, hdr_len);
            if (dg_len > cut)
                dg_len = cut;
        end
        else if (sel >= 80 && sel < 90)
        begin
            case ($urandom_range(0, 2))
                0:       datagram[2] = sup_pkg::FRAG_BAD;
                1:
                begin
                    if (datagram[3] == sup_pkg::ATYP_DOM)
                        datagram[4] = 8'd0;
                    else
                        datagram[2] = sup_pkg::FRAG_BAD;
                end
                default:
                begin
                    do
                        bad = 8'($urandom);
                    while (bad == sup_pkg::ATYP_V4 || bad == sup_pkg::ATYP_V6 ||
                           bad == sup_pkg::ATYP_DOM);
                    datagram[3] = bad;
                end
            endcase
        end
        else if (sel >= 90)
        begin
            dg_len = 0;
            repeat ($urandom_range(1, 24)) dg_add(8'($urandom));
        end
    endfunction

    task automatic send_datagram();
        bit has;
        sup_pkg::res_t r;
        for (int i = 0; i < dg_len; i++)
        begin
            offer_byte(datagram[i], i == dg_len - 1, has, r);
            if (has)
                owe_result(r);
            sender_pause();
        end
        datagrams++;
    endtask

    // ------------------------------------------------------------------------
    // result side: random ready, field-by-field check on every accepted item
    // ------------------------------------------------------------------------
    task automatic cmp_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
        if (got !== want)
            report($sformatf("result %0d field %s: got 0x%0h, expected 0x%0h",
                             results_seen, name, got, want));
    endtask

    task automatic check_result();
        sup_pkg::res_t got;
        sup_pkg::res_t want;
        got.kind            = sup_pkg::kind_t'(dout_if.kind);
        got.byte_out        = dout_if.byte_out;
        got.address_index   = dout_if.address_index;
        got.address_kind    = dout_if.address_kind;
        got.address_length  = dout_if.address_length;
        got.dest_port       = dout_if.dest_port;
        got.fragment_number = dout_if.fragment_number;
        got.fragment_final  = dout_if.fragment_final;
        got.standalone      = dout_if.standalone;
        got.packet_done     = dout_if.packet_done;
        results_seen++;
        if (due_count() == 0)
        begin
            report($sformatf("result %0d (kind %0d) arrived with nothing expected",
                             results_seen, got.kind));
            return;
        end
        want = take_result();
        kind_seen[want.kind]++;
        cmp_field("kind", got.kind, want.kind);
        cmp_field("byte_out", got.byte_out, want.byte_out);
        cmp_field("address_index", got.address_index, want.address_index);
        cmp_field("address_kind", got.address_kind, want.address_kind);
        cmp_field("address_length", got.address_length, want.address_length);
        cmp_field("dest_port", got.dest_port, want.dest_port);
        cmp_field("fragment_number", got.fragment_number, want.fragment_number);
        cmp_field("fragment_final", got.fragment_final, want.fragment_final);
        cmp_field("standalone", got.standalone, want.standalone);
        cmp_field("packet_done", got.packet_done, want.packet_done);
    endtask

    initial
    begin : result_side
        int stall;
        int cyc;
        stall    = 0;
        cyc      = 0;
        sink_pct = 20;
        dout_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            // valid and ready seen here are the values the edge sampled
            if (dout_if.valid && dout_if.ready)
                check_result();
            // the stall rate is redrawn by pick_pct, zero included
            cyc++;
            if (cyc % 200 == 0)
                sink_pct = pick_pct();
            if (stall > 0)
            begin
                stall--;
                dout_if.ready <= 1'b0;
            end
            else
            begin
                dout_if.ready <= 1'b1;
                stall = pick_gap(sink_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // run limit
    // ------------------------------------------------------------------------
    initial
    begin
        #8_000_000;
        $display("socks5_udp_header_parser regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        sup_pkg::res_t drop_r;
        sup_pkg::res_t hdr_r;
        sup_pkg::res_t pay_r;
        sup_pkg::res_t r;
        bit has;
        int w;

        errors       = 0;
        bytes_sent   = 0;
        datagrams    = 0;
        results_seen = 0;
        kind_seen    = '{0, 0, 0, 0};
        src_pct      = 15;
        due_wr       = 0;
        due_rd       = 0;
        n_rows       = 0;
        dg_len       = 0;
        reset_parse();

        rst_n                <= 1'b0;
        din_if.valid         <= 1'b0;
        din_if.byte_in       <= 8'h00;
        din_if.end_of_packet <= 1'b0;

        drop_r             = '0;
        drop_r.kind        = sup_pkg::KIND_DROP;
        drop_r.packet_done = 1'b1;

        // one-byte domain, fragment byte ff, port ffff: fragment and port fields at their top
        hdr_r                 = '0;
        hdr_r.kind            = sup_pkg::KIND_HDR;
        hdr_r.address_kind    = sup_pkg::AKIND_DOM;
        hdr_r.address_length  = 8'd1;
        hdr_r.dest_port       = 16'hffff;
        hdr_r.fragment_number = 7'h7f;
        hdr_r.fragment_final  = 1'b1;

        pay_r             = '0;
        pay_r.kind        = sup_pkg::KIND_PAY;
        pay_r.packet_done = 1'b1;

        // straight after reset the datagram ends on its first reserved byte
        add_row(8'h00, 1'b1, ROW_FIXED, drop_r);
        // reserved bytes are never checked; fragment byte 0x80 drops and the
        // rest of the datagram, its last byte too, gives nothing
        add_row(8'hff, 1'b0, ROW_NONE, '0);
        add_row(8'hff, 1'b0, ROW_NONE, '0);
        add_row(sup_pkg::FRAG_BAD, 1'b0, ROW_FIXED, drop_r);
        add_row(8'h55, 1'b1, ROW_NONE, '0);
        // unknown address type on the final byte: drop, no swallowing needed
        add_row(8'h00, 1'b0, ROW_NONE, '0);
        add_row(8'h00, 1'b0, ROW_NONE, '0);
        add_row(8'h00, 1'b0, ROW_NONE, '0);
        add_row(8'h02, 1'b1, ROW_FIXED, drop_r);
        // domain name with a zero length byte
        add_row(8'h00, 1'b0, ROW_NONE, '0);
        add_row(8'h00, 1'b0, ROW_NONE, '0);
        add_row(8'h00, 1'b0, ROW_NONE, '0);
        add_row(sup_pkg::ATYP_DOM, 1'b0, ROW_NONE, '0);
        add_row(8'h00, 1'b1, ROW_FIXED, drop_r);
        // full request: one-byte domain, header, then a single payload byte
        add_row(8'h00, 1'b0, ROW_NONE, '0);
        add_row(8'h00, 1'b0, ROW_NONE, '0);
        add_row(8'hff, 1'b0, ROW_NONE, '0);
        add_row(sup_pkg::ATYP_DOM, 1'b0, ROW_NONE, '0);
        add_row(8'h01, 1'b0, ROW_NONE, '0);
        add_row(8'h7a, 1'b0, ROW_PREDICT, '0);
        add_row(8'hff, 1'b0, ROW_NONE, '0);
        add_row(8'hff, 1'b0, ROW_FIXED, hdr_r);
        add_row(8'h00, 1'b1, ROW_FIXED, pay_r);
        // ipv4 datagram that ends inside the address: the sent address byte is void
        add_row(8'h00, 1'b0, ROW_NONE, '0);
        add_row(8'h00, 1'b0, ROW_NONE, '0);
        add_row(8'h01, 1'b0, ROW_NONE, '0);
        add_row(sup_pkg::ATYP_V4, 1'b0, ROW_NONE, '0);
        add_row(8'haa, 1'b0, ROW_PREDICT, '0);
        add_row(8'h00, 1'b1, ROW_FIXED, drop_r);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table; the predictor runs on every row to keep its context
        for (int i = 0; i < n_rows; i++)
        begin
            offer_byte(stim_rows[i].data, stim_rows[i].eop, has, r);
            case (stim_rows[i].mode)
                ROW_PREDICT:
                begin
                    if (has)
                        owe_result(r);
                end
                ROW_FIXED: owe_result(stim_rows[i].want);
                default:   ;
            endcase
            if (stim_rows[i].eop)
                datagrams++;
            sender_pause();
        end

        // random datagrams until enough bytes have been sent
        while (bytes_sent < TOTAL_BYTES)
        begin
            src_pct = pick_pct();
            make_datagram();
            // now and then hold the input until every owed result has come out
            if (datagrams % 150 == 40)
            begin
                din_if.valid <= 1'b0;
                @(posedge clk);
                while (due_count() != 0)
                    @(posedge clk);
            end
            send_datagram();
        end
        din_if.valid <= 1'b0;

        // drain, bounded so a missing result ends as a leftover report
        for (w = 0; w < 5000 && due_count() != 0; w++)
            @(posedge clk);
        // then keep the clock running to catch any stray result
        repeat (10) @(posedge clk);
        for (w = due_rd; w < due_wr; w++)
            report($sformatf("expected result of kind %0d never arrived",
                             due_buf[w % DUE_DEPTH].kind));

        $display("sent %0d datagrams (%0d bytes) with random stalls on both sides",
                 datagrams, bytes_sent);
        $display("checked %0d address, %0d header, %0d payload and %0d drop results",
                 kind_seen[sup_pkg::KIND_ADDR], kind_seen[sup_pkg::KIND_HDR],
                 kind_seen[sup_pkg::KIND_PAY], kind_seen[sup_pkg::KIND_DROP]);
        if (errors == 0)
            $display("socks5_udp_header_parser regression: pass");
        else
            $display("socks5_udp_header_parser regression: fail");
        $finish;
    end

endmodule

// ===== files.f =====
src/sup_pkg.sv
src/sup_in_if.sv
src/sup_out_if.sv
src/sup_step.sv
src/sup_out_reg.sv
src/socks5_udp_header_parser.sv
tb/socks5_udp_header_parser_test.sv
